@@ rtl/core/stq_pkg.sv @@
// Shared constants, types and helpers for the segment to thick quad block.
// No dependencies; imported by every module under rtl/core.
`default_nettype none
package stq_pkg;
    localparam int MAX_QUADS   = 256;
    localparam int CNT_W       = $clog2(MAX_QUADS + 1);
    localparam int IDX_W       = 8;
    localparam int COORD_W     = 14;
    localparam int VERT_W      = 16;
    localparam int COLOR_W     = 32;
    localparam int HT_W        = 8;
    localparam int SCR_CX_Q4   = 2560;
    localparam int SCR_CY_Q4   = 1920;
    // Square root works on len2 << 24 (up to 54 bits), root fits 28 bits.
    localparam int RAD_W       = 56;
    localparam int ROOT_W      = 28;
    // Numerator |d| * h * 2^24: 15 + 8 + 24 bits.
    localparam int NUM_W       = 47;
    localparam int QUO_W       = 47;
    localparam int PADDR_W     = 4;

    localparam logic [PADDR_W-1:0] ADDR_HALF  = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_CLASS = 4'h4;
    localparam logic [PADDR_W-1:0] ADDR_COLOR = 4'h8;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQRT, ST_DIVX, ST_DIVY, ST_OUT
    } stq_state_t;
endpackage
`default_nettype wire

@@ rtl/core/stq_sqrt.sv @@
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on stq_pkg.
`default_nettype none
module stq_sqrt (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [stq_pkg::RAD_W-1:0] radicand,
    output logic                           busy,
    output logic [stq_pkg::ROOT_W-1:0]     root
);
    import stq_pkg::*;
    localparam int STEPS = RAD_W / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W+1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [ROOT_W+1:0] trial;
    logic [ROOT_W+1:0] shifted;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        shifted   = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(STEPS);
        end
        else if (cnt_reg != '0)
        begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = (cnt_reg != '0);
    assign root = root_reg;
endmodule
`default_nettype wire

@@ rtl/core/stq_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle, unsigned.
// Depends on stq_pkg.
`default_nettype none
module stq_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [stq_pkg::NUM_W-1:0]  dividend,
    input  wire logic [stq_pkg::ROOT_W-1:0] divisor,
    output logic                            busy,
    output logic [stq_pkg::QUO_W-1:0]       quotient
);
    import stq_pkg::*;
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [ROOT_W:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0] den_reg, den_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [ROOT_W:0]   shifted;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        shifted  = {rem_reg[ROOT_W-1:0], quo_reg[NUM_W-1]};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
            cnt_next = CW'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;
endmodule
`default_nettype wire

@@ rtl/core/segment_to_thick_quad.sv @@
// Top level: segment to thick quad with APB registers and sequencer.
// Depends on stq_pkg, stq_sqrt and stq_div.
//
//  channel | valid   | ready   | payload
//  in      | valid   | ready   | start_x..end_of_pass
//  out     | o_valid | o_ready | quad_index, eight vertices, vertex_color
//  apb     | psel    | pready  | paddr, pwdata, prdata
//
// A kept segment runs through the serial square root and then the one shared
// divider twice, first for the x offset and then for the y offset, before output.
// A rejected segment is dropped in the idle state. One segment is in flight at a time.
// Reset clears the sequencer, counters and registers to their reset values.
// A result waits in the output register; the next segment is taken meanwhile.
`default_nettype none
module segment_to_thick_quad (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [stq_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  wire logic                         valid,
    output logic                              ready,
    input  wire logic [stq_pkg::COORD_W-1:0]  start_x,
    input  wire logic [stq_pkg::COORD_W-1:0]  start_y,
    input  wire logic [stq_pkg::COORD_W-1:0]  end_x,
    input  wire logic [stq_pkg::COORD_W-1:0]  end_y,
    input  wire logic                         is_border,
    input  wire logic                         end_of_pass,
    output logic                              o_valid,
    input  wire logic                         o_ready,
    output logic [stq_pkg::IDX_W-1:0]         quad_index,
    output logic signed [stq_pkg::VERT_W-1:0] start_plus_x,
    output logic signed [stq_pkg::VERT_W-1:0] start_plus_y,
    output logic signed [stq_pkg::VERT_W-1:0] start_minus_x,
    output logic signed [stq_pkg::VERT_W-1:0] start_minus_y,
    output logic signed [stq_pkg::VERT_W-1:0] end_plus_x,
    output logic signed [stq_pkg::VERT_W-1:0] end_plus_y,
    output logic signed [stq_pkg::VERT_W-1:0] end_minus_x,
    output logic signed [stq_pkg::VERT_W-1:0] end_minus_y,
    output logic [stq_pkg::COLOR_W-1:0]       vertex_color
);
    import stq_pkg::*;

    // Registers.
    logic [HT_W-1:0]    half_reg;
    logic               class_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg  <= HT_W'(16);
            class_reg <= 1'b0;
            color_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr)
                ADDR_HALF:  half_reg  <= pwdata[HT_W-1:0];
                ADDR_CLASS: class_reg <= pwdata[0];
                ADDR_COLOR: color_reg <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_HALF:  prdata = {{(32-HT_W){1'b0}}, half_reg};
            ADDR_CLASS: prdata = {31'b0, class_reg};
            ADDR_COLOR: prdata = color_reg;
            default:    prdata = '0;
        endcase
    end

    // Segment working registers, world Q.4 coordinates.
    stq_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic signed [15:0] wx0_reg, wy0_reg, wx1_reg, wy1_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic               last_reg;
    logic               dxneg_reg, dyneg_reg;
    logic [HT_W-1:0]    h_reg;
    logic [QUO_W-1:0]   nxmag_reg;
    logic               ovalid_reg;

    logic signed [15:0] wx0_c, wy0_c, wx1_c, wy1_c, dx_c, dy_c;
    logic [29:0]        len2_c;
    logic               accept, keep, long_enough;
    logic               out_free;

    assign out_free = !ovalid_reg || o_ready;
    assign accept   = valid && ready;

    assign wx0_c = 16'(signed'({2'b0, start_x})) - 16'(SCR_CX_Q4);
    assign wy0_c = 16'(SCR_CY_Q4) - 16'(signed'({2'b0, start_y}));
    assign wx1_c = 16'(signed'({2'b0, end_x})) - 16'(SCR_CX_Q4);
    assign wy1_c = 16'(SCR_CY_Q4) - 16'(signed'({2'b0, end_y}));
    assign dx_c  = wx1_c - wx0_c;
    assign dy_c  = wy1_c - wy0_c;
    // dx*dx + dy*dy >= 3 is exactly len2 * 100 >= 256 for integers.
    assign len2_c = 30'(dx_c * dx_c) + 30'(dy_c * dy_c);
    assign long_enough = (len2_c >= 30'd3);
    assign keep = (is_border == class_reg) && (count_reg < CNT_W'(MAX_QUADS))
                  && long_enough;

    // Shared units.
    logic               sq_start, sq_busy;
    logic               dv_start, dv_busy;
    logic [ROOT_W-1:0]  root;
    logic [QUO_W-1:0]   quo;
    logic [NUM_W-1:0]   num_c;
    logic [14:0]        dmag_c;

    stq_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand ({2'b00, len2_c, 24'b0}),
        .busy     (sq_busy),
        .root     (root)
    );

    // x offset uses -dy, y offset uses dx; magnitude only, sign kept aside.
    assign dmag_c = (state_reg == ST_SQRT)
                    ? (dy_reg[15] ? 15'(-dy_reg) : 15'(dy_reg))
                    : (dx_reg[15] ? 15'(-dx_reg) : 15'(dx_reg));
    assign num_c  = {NUM_W'(dmag_c * h_reg)} << 24;

    stq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (num_c),
        .divisor  (root),
        .busy     (dv_busy),
        .quotient (quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept && keep) state_next = ST_SQRT;
            ST_SQRT: if (!sq_busy) state_next = ST_DIVX;
            ST_DIVX: if (!dv_busy) state_next = ST_DIVY;
            ST_DIVY: if (!dv_busy) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ready    = (state_reg == ST_IDLE);
        sq_start = (state_reg == ST_IDLE) && accept && keep;
        dv_start = ((state_reg == ST_SQRT) && !sq_busy)
                   || ((state_reg == ST_DIVX) && !dv_busy);
    end

    always_comb
    begin
        count_next = count_reg;
        if (state_reg == ST_OUT && out_free)
            count_next = last_reg ? '0 : count_reg + 1'b1;
        else if (state_reg == ST_IDLE && accept && !keep && end_of_pass)
            count_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == ST_OUT && out_free)
                ovalid_reg <= 1'b1;
            else if (o_ready)
                ovalid_reg <= 1'b0;
        end
    end

    // Offsets at Q.16: point * 4096 +/- n, then truncate toward zero.
    function automatic logic [VERT_W-1:0] vtx(input logic signed [15:0] p,
                                              input logic [QUO_W-1:0] mag,
                                              input logic neg);
        logic signed [48:0] s;
        logic signed [48:0] a;
        s = (49'(signed'(p)) <<< 12);
        if (neg)
            s = s - 49'(signed'({1'b0, mag}));
        else
            s = s + 49'(signed'({1'b0, mag}));
        a = s[48] ? -s : s;
        a = a >>> 16;
        if (s[48])
            a = -a;
        return a[VERT_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept)
        begin
            wx0_reg   <= wx0_c;
            wy0_reg   <= wy0_c;
            wx1_reg   <= wx1_c;
            wy1_reg   <= wy1_c;
            dx_reg    <= dx_c;
            dy_reg    <= dy_c;
            dxneg_reg <= dx_c[15];
            dyneg_reg <= dy_c[15];
            last_reg  <= end_of_pass;
            h_reg     <= half_reg;
        end
        if (state_reg == ST_DIVX && !dv_busy)
            nxmag_reg <= quo;
        if (state_reg == ST_OUT && out_free)
        begin
            // nx = -dy*h/len: positive magnitude when dy negative.
            quad_index    <= count_reg[IDX_W-1:0];
            start_plus_x  <= vtx(wx0_reg, nxmag_reg, !dyneg_reg);
            start_minus_x <= vtx(wx0_reg, nxmag_reg, dyneg_reg);
            end_plus_x    <= vtx(wx1_reg, nxmag_reg, !dyneg_reg);
            end_minus_x   <= vtx(wx1_reg, nxmag_reg, dyneg_reg);
            start_plus_y  <= vtx(wy0_reg, quo, dxneg_reg);
            start_minus_y <= vtx(wy0_reg, quo, !dxneg_reg);
            end_plus_y    <= vtx(wy1_reg, quo, dxneg_reg);
            end_minus_y   <= vtx(wy1_reg, quo, !dxneg_reg);
            vertex_color  <= color_reg;
        end
    end

    assign o_valid = ovalid_reg;

    ap_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !ready) else $error("ready while busy");
    ap_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(sq_busy && dv_busy)) else $error("units overlap");
    ap_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_QUADS)) else $error("count over budget");
    ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !o_ready) |=> ovalid_reg) else $error("result lost");
endmodule
`default_nettype wire
